>>> rtl/lsb_watermark_extractor_assert.svh
// assertion macros for the watermark extractor
`ifndef LSB_WATERMARK_EXTRACTOR_ASSERT_SVH
`define LSB_WATERMARK_EXTRACTOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LWE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LWE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/lwe_pkg.sv
// package: shared widths, constants and types of the watermark extractor
package lwe_pkg;

   localparam int BYTE_W          = 8;
   localparam int LEN_W           = 16;
   localparam int HEADER_BITS_DEF = 32;
   localparam int BIT_CNT_W       = 3;

   localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(1000);

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_HEADER = 4'b0010,
      PH_DATA   = 4'b0100,
      PH_DONE   = 4'b1000
   } lwe_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] blue_value;
      logic              frame_start;
   } lwe_pix_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
      logic              length_error;
   } lwe_res_type;

   typedef struct packed {
      logic pix_pop;
      logic res_load;
   } lwe_ctrl_type;

   typedef struct packed {
      logic done;
   } lwe_stat_type;

endpackage

>>> rtl/lwe_if.sv
// interfaces: pixel request channel and byte response channel
interface lwe_req_if;
   logic                            valid;
   logic                            ready;
   logic [lwe_pkg::BYTE_W-1:0]      blue_value;
   logic                            frame_start;

   modport source (output valid, output blue_value, output frame_start, input ready);
   modport sink   (input valid, input blue_value, input frame_start, output ready);
endinterface

interface lwe_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lwe_pkg::BYTE_W-1:0]      data_byte;
   logic                            last_byte;
   logic                            length_error;

   modport source (output valid, output data_byte, output last_byte, output length_error,
                   input ready);
   modport sink   (input valid, input data_byte, input last_byte, input length_error,
                   output ready);
endinterface

>>> rtl/lsb_watermark_extractor.sv
// top level: lsb watermark extractor
// path: a pixel item is registered in the input register, then its byte item (if any)
//   is loaded into the result register when the core takes that pixel
// throughput: one pixel item per cycle while the response side takes items
// reset: synchronous, clears both stage valid flags and the extraction state,
//   sets max_length to 1000; pixels are ignored until a frame start
module lsb_watermark_extractor #(
   parameter int HEADER_BITS = lwe_pkg::HEADER_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [lwe_pkg::LEN_W-1:0] csr_wr_data,
   lwe_req_if.sink                   req_ch,
   lwe_rsp_if.source                 rsp_ch
);

`include "lsb_watermark_extractor_assert.svh"

   logic                  pix_vld;
   lwe_pkg::lwe_pix_type  pix;
   logic                  out_free;
   lwe_pkg::lwe_ctrl_type ctrl;
   lwe_pkg::lwe_res_type  res;
   lwe_pkg::lwe_stat_type stat;

   lwe_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .out_free (out_free),
      .ctrl     (ctrl),
      .pix_vld  (pix_vld),
      .pix      (pix)
   );

   lwe_core #(
      .HEADER_BITS (HEADER_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pix_vld     (pix_vld),
      .pix         (pix),
      .out_free    (out_free),
      .ctrl        (ctrl),
      .res         (res),
      .stat        (stat)
   );

   lwe_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .res      (res),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

   `LWE_ASSERT_NOW(a_err_item_clean, clock, reset, rsp_ch.valid && rsp_ch.length_error, rsp_ch.data_byte == '0 && !rsp_ch.last_byte, "error item carries data")
   `LWE_ASSERT_NEXT(a_end_to_done, clock, reset, ctrl.res_load && (res.last_byte || res.length_error), stat.done, "core not done after final item")
   `LWE_ASSERT_NOW(a_rsp_from_load, clock, reset, $rose(rsp_ch.valid), $past(ctrl.res_load), "response valid without a load")

endmodule

>>> rtl/lwe_in_stage.sv
// input register: holds one pixel item until the core takes it
module lwe_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   lwe_req_if.sink              req_ch,
   input  logic                 out_free,
   input  lwe_pkg::lwe_ctrl_type ctrl,
   output logic                 pix_vld,
   output lwe_pkg::lwe_pix_type pix
);

   logic                 vld_ff;
   logic                 vld_in;
   lwe_pkg::lwe_pix_type pix_ff;
   logic                 load;

   assign req_ch.ready = !vld_ff || out_free;
   assign load         = req_ch.valid && req_ch.ready;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (ctrl.pix_pop) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff.blue_value  <= req_ch.blue_value;
         pix_ff.frame_start <= req_ch.frame_start;
      end
   end

   assign pix_vld = vld_ff;
   assign pix     = pix_ff;

endmodule

>>> rtl/lwe_core.sv
// extraction core: header and byte assembly state, length check
module lwe_core #(
   parameter int HEADER_BITS = lwe_pkg::HEADER_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [lwe_pkg::LEN_W-1:0]      csr_wr_data,
   input  logic                           pix_vld,
   input  lwe_pkg::lwe_pix_type           pix,
   input  logic                           out_free,
   output lwe_pkg::lwe_ctrl_type          ctrl,
   output lwe_pkg::lwe_res_type           res,
   output lwe_pkg::lwe_stat_type          stat
);

   localparam int HCNT_W = $clog2(HEADER_BITS + 1);
   localparam int CMP_W  = (HEADER_BITS > lwe_pkg::LEN_W) ? HEADER_BITS : lwe_pkg::LEN_W;

   logic [lwe_pkg::LEN_W-1:0]      max_len_ff;
   lwe_pkg::lwe_phase_type         phase_ff, phase_in, phase_cur;
   logic [HEADER_BITS-1:0]         hdr_ff, hdr_in, hdr_cur;
   logic [HCNT_W-1:0]              hcnt_ff, hcnt_in, hcnt_cur;
   logic [lwe_pkg::BYTE_W-1:0]     bsh_ff, bsh_in, bsh_cur;
   logic [lwe_pkg::BIT_CNT_W-1:0]  bib_ff, bib_in, bib_cur;
   logic [lwe_pkg::LEN_W-1:0]      mlen_ff, mlen_in, mlen_cur;
   logic [lwe_pkg::LEN_W-1:0]      sent_ff, sent_in, sent_cur;
   logic [CMP_W-1:0]               hdr_ext;
   logic                           bit_lsb;
   logic                           take;
   logic                           res_vld;

   assign bit_lsb = pix.blue_value[0];
   assign take    = pix_vld && out_free;

   always_comb begin
      phase_cur = phase_ff;
      hdr_cur   = hdr_ff;
      hcnt_cur  = hcnt_ff;
      bsh_cur   = bsh_ff;
      bib_cur   = bib_ff;
      mlen_cur  = mlen_ff;
      sent_cur  = sent_ff;
      // frame start restarts extraction, this pixel is header bit one
      if (pix.frame_start) begin
         phase_cur = lwe_pkg::PH_HEADER;
         hdr_cur   = '0;
         hcnt_cur  = '0;
         bsh_cur   = '0;
         bib_cur   = '0;
         mlen_cur  = '0;
         sent_cur  = '0;
      end

      phase_in = phase_cur;
      hdr_in   = hdr_cur;
      hcnt_in  = hcnt_cur;
      bsh_in   = bsh_cur;
      bib_in   = bib_cur;
      mlen_in  = mlen_cur;
      sent_in  = sent_cur;
      hdr_ext  = '0;
      res_vld  = 1'b0;
      res      = '0;

      unique case (phase_cur)
         lwe_pkg::PH_HEADER: begin
            hdr_in  = {hdr_cur[HEADER_BITS-2:0], bit_lsb};
            hcnt_in = hcnt_cur + HCNT_W'(1);
            hdr_ext = CMP_W'(hdr_in);
            if (hcnt_in == HCNT_W'(HEADER_BITS)) begin
               if (hdr_in == '0 || hdr_ext > CMP_W'(max_len_ff)) begin
                  phase_in         = lwe_pkg::PH_DONE;
                  res_vld          = 1'b1;
                  res.length_error = 1'b1;
               end else begin
                  mlen_in  = hdr_ext[lwe_pkg::LEN_W-1:0];
                  sent_in  = '0;
                  bsh_in   = '0;
                  bib_in   = '0;
                  phase_in = lwe_pkg::PH_DATA;
               end
            end
         end
         lwe_pkg::PH_DATA: begin
            bsh_in = {bsh_cur[lwe_pkg::BYTE_W-2:0], bit_lsb};
            bib_in = bib_cur + lwe_pkg::BIT_CNT_W'(1);
            if (bib_in == '0) begin
               sent_in       = sent_cur + lwe_pkg::LEN_W'(1);
               res_vld       = 1'b1;
               res.data_byte = bsh_in;
               res.last_byte = (sent_in == mlen_cur);
               if (sent_in == mlen_cur) begin
                  phase_in = lwe_pkg::PH_DONE;
               end
               bsh_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= lwe_pkg::MAX_LENGTH_RST;
         phase_ff   <= lwe_pkg::PH_IDLE;
         hdr_ff     <= '0;
         hcnt_ff    <= '0;
         bsh_ff     <= '0;
         bib_ff     <= '0;
         mlen_ff    <= '0;
         sent_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (take) begin
            phase_ff <= phase_in;
            hdr_ff   <= hdr_in;
            hcnt_ff  <= hcnt_in;
            bsh_ff   <= bsh_in;
            bib_ff   <= bib_in;
            mlen_ff  <= mlen_in;
            sent_ff  <= sent_in;
         end
      end
   end

   assign ctrl.pix_pop  = take;
   assign ctrl.res_load = take && res_vld;
   assign stat.done     = (phase_ff == lwe_pkg::PH_DONE);

endmodule

>>> rtl/lwe_out_stage.sv
// result register: holds one byte item until the sink takes it
module lwe_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  lwe_pkg::lwe_ctrl_type ctrl,
   input  lwe_pkg::lwe_res_type  res,
   output logic                  out_free,
   lwe_rsp_if.source             rsp_ch
);

   logic                 vld_ff;
   logic                 vld_in;
   lwe_pkg::lwe_res_type res_ff;

   assign out_free = !vld_ff || rsp_ch.ready;

   always_comb begin
      vld_in = vld_ff;
      if (ctrl.res_load) begin
         vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.res_load) begin
         res_ff <= res;
      end
   end

   assign rsp_ch.valid        = vld_ff;
   assign rsp_ch.data_byte    = res_ff.data_byte;
   assign rsp_ch.last_byte    = res_ff.last_byte;
   assign rsp_ch.length_error = res_ff.length_error;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// testbench: pixel frames driven into the watermark extractor, bytes checked against a predictor
module tb;

   localparam int HDR_BITS = lwe_pkg::HEADER_BITS_DEF;

   localparam logic [1:0] PAT_RANDOM = 2'd0;
   localparam logic [1:0] PAT_ONES   = 2'd1;
   localparam logic [1:0] PAT_ZEROS  = 2'd2;

   localparam lwe_pkg::lwe_res_type NO_RES  = '0;
   localparam lwe_pkg::lwe_res_type LEN_ERR = '{8'h00, 1'b0, 1'b1};

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   typedef struct packed {
      logic                 wr;
      logic [15:0]          wr_val;
      logic                 fs;
      logic [31:0]          header;
      logic [5:0]           hbits;
      logic [11:0]          dbits;
      logic [1:0]           pat;
      logic                 typed;
      lwe_pkg::lwe_res_type typed_res;
   } frame_case_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [lwe_pkg::LEN_W-1:0] csr_wr_data;

   lwe_req_if req_if ();
   lwe_rsp_if rsp_if ();

   lsb_watermark_extractor uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if)
   );

   // predictor state
   lwe_pkg::lwe_phase_type    ext_phase;
   logic [31:0]               hdr_shift;
   logic [5:0]                hdr_count;
   logic [7:0]                byte_acc;
   logic [2:0]                bit_pos;
   logic [15:0]               msg_len;
   logic [15:0]               sent_count;
   logic [lwe_pkg::LEN_W-1:0] max_len;

   lwe_pkg::lwe_res_type expected_bytes [$];
   frame_case_type       directed_frames [17];

   int          mismatches;
   int          pix_used;
   int          burst_left;
   bit          no_gaps;
   int          hold_asks;
   int          hold_seen;
   int          hold_left;
   rx_mode_type rx_mode;
   int          rx_left;
   int          rx_step;
   logic [7:0]  rx_mask;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic bit extract_step(input lwe_pkg::lwe_pix_type pix,
                                       output lwe_pkg::lwe_res_type res);
      logic b;
      b = pix.blue_value[0];
      res = NO_RES;
      if (pix.frame_start) begin
         ext_phase  = lwe_pkg::PH_HEADER;
         hdr_shift  = '0;
         hdr_count  = '0;
         byte_acc   = '0;
         bit_pos    = '0;
         msg_len    = '0;
         sent_count = '0;
      end
      if (ext_phase == lwe_pkg::PH_HEADER) begin
         hdr_shift = {hdr_shift[30:0], b};
         hdr_count = hdr_count + 6'd1;
         if (hdr_count >= HDR_BITS) begin
            if (hdr_shift == 0 || hdr_shift > {16'h0000, max_len}) begin
               ext_phase = lwe_pkg::PH_DONE;
               res = LEN_ERR;
               return 1'b1;
            end
            msg_len    = hdr_shift[15:0];
            sent_count = '0;
            byte_acc   = '0;
            bit_pos    = '0;
            ext_phase  = lwe_pkg::PH_DATA;
         end
         return 1'b0;
      end
      if (ext_phase == lwe_pkg::PH_DATA) begin
         byte_acc = {byte_acc[6:0], b};
         bit_pos  = bit_pos + 3'd1;
         if (bit_pos != 0) return 1'b0;
         sent_count     = sent_count + 16'd1;
         res.data_byte  = byte_acc;
         res.last_byte  = (sent_count == msg_len);
         if (res.last_byte) ext_phase = lwe_pkg::PH_DONE;
         byte_acc = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic note_mismatch(input string what, input lwe_pkg::lwe_res_type want,
                                input lwe_pkg::lwe_res_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected byte %02h last %0b err %0b, got byte %02h last %0b err %0b",
                  what, want.data_byte, want.last_byte, want.length_error,
                  got.data_byte, got.last_byte, got.length_error);
   endtask

   always @(posedge clock) begin
      lwe_pkg::lwe_res_type got;
      lwe_pkg::lwe_res_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.data_byte    = rsp_if.data_byte;
         got.last_byte    = rsp_if.last_byte;
         got.length_error = rsp_if.length_error;
         if (expected_bytes.size() == 0) begin
            note_mismatch("item with none pending", NO_RES, got);
         end else begin
            want = expected_bytes.pop_front();
            if (got.data_byte !== want.data_byte || got.last_byte !== want.last_byte ||
                got.length_error !== want.length_error)
               note_mismatch("wrong item", want, got);
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = 300;
      end
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(20, 80);
         rx_mask = 8'($urandom());
      end
      rx_left--;
      rx_step++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready = 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS: rsp_if.ready = 1'b1;
            RX_RANDOM: rsp_if.ready = 1'($urandom_range(0, 1));
            default:   rsp_if.ready = rx_mask[rx_step % 8];
         endcase
      end
   end

   task automatic send_pixel(input lwe_pkg::lwe_pix_type pix, input bit typed_on,
                             input lwe_pkg::lwe_res_type typed_res);
      int                   gap;
      lwe_pkg::lwe_res_type res;
      if (burst_left == 0 && !no_gaps) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_if.valid       = 1'b1;
      req_if.blue_value  = pix.blue_value;
      req_if.frame_start = pix.frame_start;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pix_used++;
      if (extract_step(pix, res)) expected_bytes.push_back(typed_on ? typed_res : res);
      @(negedge clock);
   endtask

   task automatic send_frame(input bit fs, input logic [31:0] header, input int hbits,
                             input int dbits, input logic [1:0] pat, input bit typed_on,
                             input lwe_pkg::lwe_res_type typed_res);
      lwe_pkg::lwe_pix_type pix;
      for (int i = 0; i < hbits + dbits; i++) begin
         pix.blue_value  = 8'($urandom());
         pix.frame_start = fs && i == 0;
         if (i < hbits) pix.blue_value[0] = header[HDR_BITS-1-i];
         else if (pat == PAT_ONES) pix.blue_value[0] = 1'b1;
         else if (pat == PAT_ZEROS) pix.blue_value[0] = 1'b0;
         send_pixel(pix, typed_on, typed_res);
      end
   endtask

   task automatic drain_results();
      req_if.valid = 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_max_length(input logic [lwe_pkg::LEN_W-1:0] v);
      drain_results();
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
      max_len   = v;
   endtask

   initial begin
      int                   kind;
      int                   cap;
      int                   len;
      logic [31:0]          hdr;
      logic [15:0]          v;
      lwe_pkg::lwe_pix_type pix;

      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_if.valid       = 1'b0;
      req_if.blue_value  = '0;
      req_if.frame_start = 1'b0;
      rsp_if.ready       = 1'b0;
      max_len            = lwe_pkg::MAX_LENGTH_RST;
      ext_phase          = lwe_pkg::PH_IDLE;
      hdr_shift          = '0;
      hdr_count          = '0;
      byte_acc           = '0;
      bit_pos            = '0;
      msg_len            = '0;
      sent_count         = '0;

      directed_frames = '{
         // pixels before any frame start
         '{0, 0,     0, 32'h0000_0005,     32, 40,  PAT_RANDOM, 0, NO_RES},
         '{0, 0,     1, 32'h0000_0000,     32, 16,  PAT_RANDOM, 1, LEN_ERR},
         '{0, 0,     1, 32'h0000_0001,     32, 8,   PAT_ONES,   1, '{8'hFF, 1'b1, 1'b0}},
         '{0, 0,     1, 32'h0000_0001,     32, 12,  PAT_ZEROS,  1, '{8'h00, 1'b1, 1'b0}},
         // longest allowed message, cut short mid-byte
         '{0, 0,     1, 32'd1000,          32, 11,  PAT_RANDOM, 0, NO_RES},
         '{0, 0,     1, 32'd1001,          32, 8,   PAT_RANDOM, 1, LEN_ERR},
         '{0, 0,     1, 32'h8000_0000,     32, 8,   PAT_RANDOM, 1, LEN_ERR},
         '{0, 0,     1, 32'hFFFF_FFFF,     32, 0,   PAT_RANDOM, 1, LEN_ERR},
         '{0, 0,     1, 32'h0000_0003,     32, 24,  PAT_RANDOM, 0, NO_RES},
         // header cut by a new frame
         '{0, 0,     1, 32'h0000_0004,     12, 0,   PAT_RANDOM, 0, NO_RES},
         '{0, 0,     1, 32'h0000_0002,     32, 11,  PAT_RANDOM, 0, NO_RES},
         '{1, 0,     1, 32'h0000_0001,     32, 8,   PAT_RANDOM, 1, LEN_ERR},
         '{1, 65535, 1, 32'h0000_FFFF,     32, 40,  PAT_RANDOM, 0, NO_RES},
         '{0, 0,     1, 32'h0001_0000,     32, 0,   PAT_RANDOM, 1, LEN_ERR},
         '{1, 1,     1, 32'h0000_0001,     32, 8,   PAT_RANDOM, 0, NO_RES},
         '{0, 0,     1, 32'h0000_0002,     32, 0,   PAT_RANDOM, 1, LEN_ERR},
         '{1, 1000,  1, 32'h0000_0006,     32, 48,  PAT_RANDOM, 0, NO_RES}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_frames[i]) begin
         if (directed_frames[i].wr) write_max_length(directed_frames[i].wr_val);
         send_frame(directed_frames[i].fs, directed_frames[i].header,
                    directed_frames[i].hbits, directed_frames[i].dbits,
                    directed_frames[i].pat, directed_frames[i].typed,
                    directed_frames[i].typed_res);
      end

      // back-pressure: receiver holds off while a message streams in
      drain_results();
      hold_asks++;
      no_gaps = 1'b1;
      send_frame(1'b1, 32'd4, HDR_BITS, 4 * 8, PAT_RANDOM, 1'b0, NO_RES);
      no_gaps = 1'b0;
      drain_results();

      while (pix_used < 1100) begin
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: v = 16'($urandom_range(1, 12));
               4:          v = lwe_pkg::MAX_LENGTH_RST;
               5:          v = 16'hFFFF;
               6:          v = 16'd1;
               7:          v = 16'd0;
               default:    v = 16'($urandom());
            endcase
            write_max_length(v);
         end
         cap  = (max_len == 0) ? 1 : ((max_len < 8) ? int'(max_len) : 8);
         len  = $urandom_range(1, cap);
         kind = $urandom_range(0, 19);
         if (kind < 13) begin
            send_frame(1'b1, 32'(len), HDR_BITS,
                       8 * len + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0),
                       PAT_RANDOM, 1'b0, NO_RES);
         end else if (kind < 15) begin
            if ($urandom_range(0, 1))
               send_frame(1'b1, 32'(len), $urandom_range(1, HDR_BITS - 1), 0,
                          PAT_RANDOM, 1'b0, NO_RES);
            else
               send_frame(1'b1, 32'(len), HDR_BITS, $urandom_range(0, 8 * len - 1),
                          PAT_RANDOM, 1'b0, NO_RES);
         end else if (kind < 17) begin
            if ($urandom_range(0, 1)) hdr = {1'b1, 31'($urandom())};
            else hdr = 32'(max_len) + 32'($urandom_range(1, 100));
            send_frame(1'b1, hdr, HDR_BITS, $urandom_range(0, 16), PAT_RANDOM, 1'b0, NO_RES);
         end else if (kind == 17) begin
            send_frame(1'b1, 32'h0, HDR_BITS, $urandom_range(0, 16), PAT_RANDOM, 1'b0, NO_RES);
         end else if (kind == 18) begin
            repeat ($urandom_range(10, 60)) begin
               pix.blue_value  = 8'($urandom());
               pix.frame_start = ($urandom_range(0, 39) == 0);
               send_pixel(pix, 1'b0, NO_RES);
            end
         end else begin
            send_frame(1'b0, 32'(len), HDR_BITS, 8 * len, PAT_RANDOM, 1'b0, NO_RES);
         end
      end

      drain_results();
      repeat (10) @(negedge clock);
      mismatches += expected_bytes.size();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
